/* sv/ptcp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptcp_pkg: shared types and constants of the PNG text chunk parser
// Beat structs of both channels, chunk type words, result codes and the
// PNG signature bytes.
// ---------------------------------------------------------------------------
package ptcp_pkg;

	localparam int unsigned MAX_KEYWORD_DEF = 79;
	localparam logic [15:0] ITEM_LIMIT_RST  = 16'd512;
	localparam int unsigned CFG_DATA_W      = 32;

	localparam logic CFG_TOTAL_LENGTH = 1'b0;
	localparam logic CFG_ITEM_LIMIT   = 1'b1;

	localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;
	localparam logic [31:0] TYPE_ZTXT = 32'h7A54_5874;
	localparam logic [31:0] TYPE_ITXT = 32'h6954_5874;
	localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

	localparam logic [1:0] KIND_KEYWORD  = 2'd0;
	localparam logic [1:0] KIND_VALUE    = 2'd1;
	localparam logic [1:0] KIND_ITEM_END = 2'd2;
	localparam logic [1:0] KIND_FINISH   = 2'd3;

	localparam logic [1:0] CK_TEXT = 2'd0;
	localparam logic [1:0] CK_ZTXT = 2'd1;
	localparam logic [1:0] CK_ITXT = 2'd2;
	localparam logic [1:0] CK_NONE = 2'd3;

	localparam logic [1:0] ST_ACCEPTED   = 2'd0;
	localparam logic [1:0] ST_COMPRESSED = 2'd1;
	localparam logic [1:0] ST_REJECTED   = 2'd2;

	localparam logic [2:0] FR_END_OF_DATA = 3'd0;
	localparam logic [2:0] FR_BAD_SIG     = 3'd1;
	localparam logic [2:0] FR_TRUNCATED   = 3'd2;
	localparam logic [2:0] FR_IEND        = 3'd3;
	localparam logic [2:0] FR_ITEM_LIMIT  = 3'd4;

	localparam logic [31:0] MIN_FILE_LEN = 32'd20;
	localparam logic [31:0] SIG_LEN      = 32'd8;
	localparam logic [31:0] SIG_LAST     = 32'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_file;
	} byte_beat_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] text_byte;
		logic [1:0] chunk_kind;
		logic [1:0] item_status;
		logic [2:0] finish_reason;
	} rec_beat_t;

	function automatic logic [7:0] sig_byte(input logic [2:0] idx);
		logic [7:0] v;
		case (idx)
			3'd0: v = 8'h89;
			3'd1: v = 8'h50;
			3'd2: v = 8'h4E;
			3'd3: v = 8'h47;
			3'd4: v = 8'h0D;
			3'd5: v = 8'h0A;
			3'd6: v = 8'h1A;
			default: v = 8'h0A;
		endcase
		return v;
	endfunction

	function automatic logic [1:0] chunk_kind_of(input logic [31:0] word);
		logic [1:0] k;
		if (word == TYPE_TEXT) k = CK_TEXT;
		else if (word == TYPE_ZTXT) k = CK_ZTXT;
		else if (word == TYPE_ITXT) k = CK_ITXT;
		else k = CK_NONE;
		return k;
	endfunction

endpackage

/* sv/png_text_chunk_parser.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// png_text_chunk_parser: PNG chunk walker with text chunk extraction
// Checks the signature, walks chunks by length and type, and emits keyword
// bytes, value bytes and item ends for text chunks, and a finish record.
//
//   channel  dir  handshake            beat
//   byte     in   byte_valid/stall     data_byte, first_of_file
//   rec      out  rec_valid/stall      kind, text_byte, chunk_kind, status, reason
//   wr       in   wr_en                wr_index, wr_data
//
// The parse state updates in the cycle a byte is accepted and its result,
// if any, lands in the output register.
// A new byte is taken while a result waits, as long as that result leaves
// in the same cycle. Reset clears the parse state and loads the register
// defaults; the first byte after reset counts as byte 0.
// ---------------------------------------------------------------------------
module png_text_chunk_parser #(
	parameter int unsigned MaxKeyword = ptcp_pkg::MAX_KEYWORD_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic                            wr_index,
	input  logic [ptcp_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic                            byte_valid,
	output logic                            byte_stall,
	input  ptcp_pkg::byte_beat_t            byte_beat,
	output logic                            rec_valid,
	input  logic                            rec_stall,
	output ptcp_pkg::rec_beat_t             rec_beat
);
	import ptcp_pkg::*;

	localparam int unsigned KwW = $clog2(MaxKeyword + 1);

	localparam logic [2:0] PH_SIG     = 3'd0;
	localparam logic [2:0] PH_HEADER  = 3'd1;
	localparam logic [2:0] PH_PAYLOAD = 3'd2;
	localparam logic [2:0] PH_CRC     = 3'd3;
	localparam logic [2:0] PH_DONE    = 3'd4;

	localparam logic [2:0] SUB_KEYWORD = 3'd0;
	localparam logic [2:0] SUB_VALUE   = 3'd1;
	localparam logic [2:0] SUB_SKIP    = 3'd2;
	localparam logic [2:0] SUB_FLAG    = 3'd3;
	localparam logic [2:0] SUB_METHOD  = 3'd4;
	localparam logic [2:0] SUB_LANG    = 3'd5;
	localparam logic [2:0] SUB_TRANS   = 3'd6;
	localparam logic [2:0] SUB_REJECT  = 3'd7;

	logic [31:0]    total_q;
	logic [15:0]    limit_q;
	logic [2:0]     phase_q, phase_e, phase_d;
	logic [31:0]    pos_q, pos_e, pos_d;
	logic [31:0]    len_q, len_e, len_d;
	logic [31:0]    pc_q, pc_e, pc_d;
	logic [31:0]    type_q, type_e, type_d;
	logic [2:0]     sub_q, sub_e, sub_d;
	logic [KwW-1:0] kw_q, kw_e, kw_d;
	logic [15:0]    acc_q, acc_e, acc_d;
	logic           comp_q, comp_e, comp_d;
	logic           rec_valid_q;
	rec_beat_t      rec_beat_q;

	logic           accept;
	logic           res_ok;
	rec_beat_t      res;
	logic [7:0]     b;
	logic           restart;

	assign accept     = byte_valid && !byte_stall;
	assign byte_stall = rec_valid_q && rec_stall;
	assign rec_valid  = rec_valid_q;
	assign rec_beat   = rec_beat_q;
	assign b          = byte_beat.data_byte;
	assign restart    = byte_beat.first_of_file;

	always_comb begin
		phase_e = restart ? PH_SIG : phase_q;
		pos_e   = restart ? '0 : pos_q;
		len_e   = restart ? '0 : len_q;
		pc_e    = restart ? '0 : pc_q;
		type_e  = restart ? '0 : type_q;
		sub_e   = restart ? SUB_KEYWORD : sub_q;
		kw_e    = restart ? '0 : kw_q;
		acc_e   = restart ? '0 : acc_q;
		comp_e  = restart ? 1'b0 : comp_q;
	end

	always_comb begin
		logic [2:0]  hidx;
		logic [1:0]  cidx;
		logic [1:0]  ck;
		logic [1:0]  st;
		logic [31:0] len_n;
		logic [31:0] type_n;
		logic [31:0] pc_inc;
		logic [33:0] fit_sum;
		logic        bnd_eod;
		phase_d = phase_e;
		pos_d   = pos_e + 32'd1;
		len_d   = len_e;
		pc_d    = pc_e;
		type_d  = type_e;
		sub_d   = sub_e;
		kw_d    = kw_e;
		acc_d   = acc_e;
		comp_d  = comp_e;
		res_ok  = 1'b0;
		res     = '0;
		hidx    = pc_e[2:0];
		cidx    = pc_e[1:0];
		ck      = chunk_kind_of(type_e);
		st      = ST_REJECTED;
		len_n   = (hidx < 3'd4) ? {len_e[23:0], b} : len_e;
		type_n  = (hidx < 3'd4) ? type_e : {type_e[23:0], b};
		pc_inc  = pc_e + 32'd1;
		fit_sum = {2'b00, len_n} + {2'b00, pos_e} + 34'd9;
		bnd_eod = ({1'b0, pos_e} + 33'd13) > {1'b0, total_q};
		case (phase_e)
			PH_SIG: begin
				if ((pos_e == '0 && total_q < MIN_FILE_LEN) || pos_e >= SIG_LEN ||
				    b != sig_byte(pos_e[2:0])) begin
					phase_d           = PH_DONE;
					res_ok            = 1'b1;
					res.kind          = KIND_FINISH;
					res.finish_reason = FR_BAD_SIG;
				end else if (pos_e == SIG_LAST) begin
					if (bnd_eod || acc_e >= limit_q) begin
						phase_d           = PH_DONE;
						res_ok            = 1'b1;
						res.kind          = KIND_FINISH;
						res.finish_reason = bnd_eod ? FR_END_OF_DATA : FR_ITEM_LIMIT;
					end else begin
						phase_d = PH_HEADER;
						pc_d    = '0;
						len_d   = '0;
						type_d  = '0;
					end
				end
			end
			PH_HEADER: begin
				pc_d   = {29'd0, hidx} + 32'd1;
				len_d  = len_n;
				type_d = type_n;
				if (hidx == 3'd3 && (pos_e < 32'd3 || fit_sum > {2'b00, total_q})) begin
					phase_d           = PH_DONE;
					res_ok            = 1'b1;
					res.kind          = KIND_FINISH;
					res.finish_reason = FR_TRUNCATED;
				end else if (hidx == 3'd7) begin
					if (type_n == TYPE_IEND) begin
						phase_d           = PH_DONE;
						res_ok            = 1'b1;
						res.kind          = KIND_FINISH;
						res.finish_reason = FR_IEND;
					end else begin
						sub_d   = SUB_KEYWORD;
						kw_d    = '0;
						comp_d  = 1'b0;
						pc_d    = '0;
						phase_d = (len_e == '0) ? PH_CRC : PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				if (ck != CK_NONE) begin
					case (sub_e)
						SUB_KEYWORD: begin
							if (b != 8'd0) begin
								if (kw_e >= KwW'(MaxKeyword)) begin
									sub_d = SUB_REJECT;
								end else begin
									kw_d           = kw_e + 1'b1;
									res_ok         = 1'b1;
									res.kind       = KIND_KEYWORD;
									res.text_byte  = b;
									res.chunk_kind = ck;
								end
							end else if (kw_e == '0) begin
								sub_d = SUB_REJECT;
							end else if (ck == CK_TEXT) begin
								sub_d = SUB_VALUE;
							end else if (ck == CK_ZTXT) begin
								sub_d = SUB_SKIP;
							end else begin
								sub_d = SUB_FLAG;
							end
						end
						SUB_VALUE: begin
							res_ok         = 1'b1;
							res.kind       = KIND_VALUE;
							res.text_byte  = b;
							res.chunk_kind = ck;
						end
						SUB_FLAG: begin
							comp_d = (b != 8'd0);
							sub_d  = SUB_METHOD;
						end
						SUB_METHOD: begin
							sub_d = SUB_LANG;
						end
						SUB_LANG: begin
							if (b == 8'd0) sub_d = SUB_TRANS;
						end
						SUB_TRANS: begin
							if (b == 8'd0) sub_d = comp_e ? SUB_SKIP : SUB_VALUE;
						end
						default: begin
						end
					endcase
				end
				if (pc_inc >= len_e) begin
					phase_d = PH_CRC;
					pc_d    = '0;
				end else begin
					pc_d = pc_inc;
				end
			end
			PH_CRC: begin
				pc_d = {30'd0, cidx} + 32'd1;
				if (cidx == 2'd0 && ck != CK_NONE) begin
					if (sub_e == SUB_VALUE) st = ST_ACCEPTED;
					else if (sub_e == SUB_SKIP) st = ST_COMPRESSED;
					else st = ST_REJECTED;
					if (st != ST_REJECTED && acc_e != 16'hFFFF) acc_d = acc_e + 16'd1;
					res_ok          = 1'b1;
					res.kind        = KIND_ITEM_END;
					res.chunk_kind  = ck;
					res.item_status = st;
				end else if (cidx == 2'd3) begin
					if (bnd_eod || acc_e >= limit_q) begin
						phase_d           = PH_DONE;
						res_ok            = 1'b1;
						res.kind          = KIND_FINISH;
						res.finish_reason = bnd_eod ? FR_END_OF_DATA : FR_ITEM_LIMIT;
					end else begin
						phase_d = PH_HEADER;
						pc_d    = '0;
						len_d   = '0;
						type_d  = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			limit_q <= ITEM_LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_TOTAL_LENGTH: total_q <= wr_data;
				CFG_ITEM_LIMIT:   limit_q <= wr_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIG;
			pos_q       <= '0;
			len_q       <= '0;
			pc_q        <= '0;
			type_q      <= '0;
			sub_q       <= SUB_KEYWORD;
			kw_q        <= '0;
			acc_q       <= '0;
			comp_q      <= 1'b0;
			rec_valid_q <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			len_q       <= len_d;
			pc_q        <= pc_d;
			type_q      <= type_d;
			sub_q       <= sub_d;
			kw_q        <= kw_d;
			acc_q       <= acc_d;
			comp_q      <= comp_d;
			rec_valid_q <= res_ok;
		end else if (!rec_stall) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_ok) begin
			rec_beat_q <= res;
		end
	end

endmodule

/* tb/tb_png_text_chunk_parser.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_png_text_chunk_parser: self-checking bench for the PNG text chunk parser
// Builds PNG files byte by byte, streams them with random gaps and output
// stalls, and predicts every keyword, value, item-end and finish beat with a
// parser model of its own. Each result beat is compared field by field.
// ---------------------------------------------------------------------------
module tb_png_text_chunk_parser;
	import ptcp_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int TOTAL_BYTES    = 1600;
	localparam int CHUNK_OVERHEAD = 12;
	localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
		8'h0D, 8'h0A, 8'h1A, 8'h0A};

	typedef enum logic [2:0] {
		PHASE_SIG, PHASE_HEADER, PHASE_PAYLOAD, PHASE_CRC, PHASE_DONE
	} parse_phase_t;

	typedef enum logic [2:0] {
		SUB_KEYWORD, SUB_VALUE, SUB_SKIP, SUB_FLAG, SUB_METHOD, SUB_LANG,
		SUB_TRANS, SUB_REJECT
	} text_sub_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  wr_en      = 1'b0;
	logic                  wr_index   = 1'b0;
	logic [CFG_DATA_W-1:0] wr_data    = '0;
	logic                  byte_valid = 1'b0;
	logic                  byte_stall;
	byte_beat_t            byte_beat  = '0;
	logic                  rec_valid;
	logic                  rec_stall  = 1'b0;
	rec_beat_t             rec_beat;

	png_text_chunk_parser i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_beat  (byte_beat),
		.rec_valid  (rec_valid),
		.rec_stall  (rec_stall),
		.rec_beat   (rec_beat)
	);

	always #4 clk = ~clk;

	// Parser model state.
	logic [31:0]  m_total    = '0;
	logic [15:0]  m_limit    = ITEM_LIMIT_RST;
	parse_phase_t m_phase    = PHASE_SIG;
	logic [31:0]  m_pos      = '0;
	logic [31:0]  m_len      = '0;
	logic [31:0]  m_cnt      = '0;
	logic [31:0]  m_type     = '0;
	text_sub_t    m_sub      = SUB_KEYWORD;
	logic [6:0]   m_kw       = '0;
	logic [15:0]  m_accepted = '0;
	logic         m_compressed = 1'b0;

	rec_beat_t   expected_recs[$];
	logic [7:0]  file_buf[$];
	logic [7:0]  body_buf[$];
	int          errors     = 0;
	int          cycles     = 0;
	int          sent_bytes = 0;
	int          burst_left = 0;
	bit          pace_on    = 1'b1;
	int          hold_req   = 0;
	int          hold_left  = 0;
	int          stall_pct  = 0;
	int          mode_left  = 0;

	function automatic void restart_parse();
		m_phase      = PHASE_SIG;
		m_pos        = '0;
		m_len        = '0;
		m_cnt        = '0;
		m_type       = '0;
		m_sub        = SUB_KEYWORD;
		m_kw         = '0;
		m_accepted   = '0;
		m_compressed = 1'b0;
	endfunction

	function automatic rec_beat_t finish_rec(input logic [2:0] why);
		rec_beat_t r;
		m_phase = PHASE_DONE;
		r = '0;
		r.kind = KIND_FINISH;
		r.finish_reason = why;
		return r;
	endfunction

	function automatic logic [1:0] current_kind();
		case (m_type)
			TYPE_TEXT: return CK_TEXT;
			TYPE_ZTXT: return CK_ZTXT;
			TYPE_ITXT: return CK_ITXT;
			default:   return CK_NONE;
		endcase
	endfunction

	function automatic bit at_boundary(input longint unsigned start, output rec_beat_t r);
		r = '0;
		if (start + CHUNK_OVERHEAD > 64'(m_total)) begin
			r = finish_rec(FR_END_OF_DATA);
			return 1'b1;
		end
		if (m_accepted >= m_limit) begin
			r = finish_rec(FR_ITEM_LIMIT);
			return 1'b1;
		end
		m_phase = PHASE_HEADER;
		m_cnt   = '0;
		m_len   = '0;
		m_type  = '0;
		return 1'b0;
	endfunction

	function automatic bit text_step(input logic [7:0] b, input logic [1:0] ck,
			output rec_beat_t r);
		r = '0;
		r.chunk_kind = ck;
		case (m_sub)
			SUB_KEYWORD: begin
				if (b != 8'd0) begin
					if (m_kw >= MAX_KEYWORD_DEF) begin
						m_sub = SUB_REJECT;
						return 1'b0;
					end
					m_kw++;
					r.kind = KIND_KEYWORD;
					r.text_byte = b;
					return 1'b1;
				end
				if (m_kw == 0) m_sub = SUB_REJECT;
				else if (ck == CK_TEXT) m_sub = SUB_VALUE;
				else if (ck == CK_ZTXT) m_sub = SUB_SKIP;
				else m_sub = SUB_FLAG;
			end
			SUB_VALUE: begin
				r.kind = KIND_VALUE;
				r.text_byte = b;
				return 1'b1;
			end
			SUB_FLAG: begin
				m_compressed = (b != 8'd0);
				m_sub = SUB_METHOD;
			end
			SUB_METHOD: m_sub = SUB_LANG;
			SUB_LANG: if (b == 8'd0) m_sub = SUB_TRANS;
			SUB_TRANS: if (b == 8'd0) m_sub = m_compressed ? SUB_SKIP : SUB_VALUE;
			default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic bit parse_byte(input byte_beat_t bb, output rec_beat_t r);
		logic [31:0]     cur;
		logic [2:0]      idx;
		logic [1:0]      ck;
		logic [1:0]      st;
		longint unsigned start;
		longint unsigned total64;
		bit              got;
		r = '0;
		got = 1'b0;
		if (bb.first_of_file) restart_parse();
		cur = m_pos;
		m_pos = m_pos + 32'd1;
		total64 = 64'(m_total);
		case (m_phase)
			PHASE_SIG: begin
				if (cur == 0 && m_total < MIN_FILE_LEN) begin
					r = finish_rec(FR_BAD_SIG);
					return 1'b1;
				end
				if (cur >= SIG_LEN || bb.data_byte != PNG_SIG[cur[2:0]]) begin
					r = finish_rec(FR_BAD_SIG);
					return 1'b1;
				end
				if (cur == SIG_LAST) got = at_boundary(64'(cur) + 1, r);
			end
			PHASE_HEADER: begin
				idx = m_cnt[2:0];
				m_cnt = 32'(idx) + 32'd1;
				if (idx < 3'd4) m_len = {m_len[23:0], bb.data_byte};
				else m_type = {m_type[23:0], bb.data_byte};
				if (idx == 3'd3) begin
					start = 64'(cur) - 3;
					if (cur < 3 || start + CHUNK_OVERHEAD > total64 ||
							64'(m_len) > total64 - start - CHUNK_OVERHEAD) begin
						r = finish_rec(FR_TRUNCATED);
						return 1'b1;
					end
				end
				if (idx == 3'd7) begin
					if (m_type == TYPE_IEND) begin
						r = finish_rec(FR_IEND);
						return 1'b1;
					end
					m_sub = SUB_KEYWORD;
					m_kw = '0;
					m_compressed = 1'b0;
					m_cnt = '0;
					m_phase = (m_len == 0) ? PHASE_CRC : PHASE_PAYLOAD;
				end
			end
			PHASE_PAYLOAD: begin
				ck = current_kind();
				if (ck != CK_NONE) got = text_step(bb.data_byte, ck, r);
				m_cnt++;
				if (m_cnt >= m_len) begin
					m_phase = PHASE_CRC;
					m_cnt = '0;
				end
			end
			PHASE_CRC: begin
				idx = {1'b0, m_cnt[1:0]};
				m_cnt = 32'(idx) + 32'd1;
				if (idx == 3'd0) begin
					ck = current_kind();
					if (ck != CK_NONE) begin
						if (m_sub == SUB_VALUE) st = ST_ACCEPTED;
						else if (m_sub == SUB_SKIP) st = ST_COMPRESSED;
						else st = ST_REJECTED;
						if (st != ST_REJECTED && m_accepted != 16'hFFFF) m_accepted++;
						r.kind = KIND_ITEM_END;
						r.chunk_kind = ck;
						r.item_status = st;
						got = 1'b1;
					end
				end
				if (idx == 3'd3) got = at_boundary(64'(cur) + 1, r);
			end
			default: ;
		endcase
		return got;
	endfunction

	// File construction.
	function automatic void put_random(input int n, input bit nonzero);
		repeat (n) body_buf.insert(body_buf.size(), nonzero ? 8'($urandom_range(1, 255))
			: 8'($urandom_range(0, 255)));
	endfunction

	function automatic void begin_file();
		file_buf.delete();
		for (int i = 0; i < 8; i++) file_buf.insert(file_buf.size(), PNG_SIG[i]);
	endfunction

	function automatic void push_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--) file_buf.insert(file_buf.size(), w[8*i +: 8]);
	endfunction

	function automatic void add_chunk(input logic [31:0] ctype);
		push_word(32'(body_buf.size()));
		push_word(ctype);
		foreach (body_buf[i]) file_buf.insert(file_buf.size(), body_buf[i]);
		push_word($urandom);
		body_buf.delete();
	endfunction

	function automatic void add_text_chunk(input logic [1:0] ck, input int kw_len,
			input bit compressed, input int value_len, input int drop);
		logic [31:0] ctype;
		put_random(kw_len, 1'b1);
		body_buf.insert(body_buf.size(), 8'd0);
		case (ck)
			CK_TEXT: ctype = TYPE_TEXT;
			CK_ZTXT: begin
				ctype = TYPE_ZTXT;
				body_buf.insert(body_buf.size(), 8'd0);
			end
			default: begin
				ctype = TYPE_ITXT;
				body_buf.insert(body_buf.size(),
					compressed ? 8'($urandom_range(1, 255)) : 8'd0);
				body_buf.insert(body_buf.size(), 8'($urandom_range(0, 255)));
				put_random($urandom_range(0, 3), 1'b1);
				body_buf.insert(body_buf.size(), 8'd0);
				put_random($urandom_range(0, 3), 1'b1);
				body_buf.insert(body_buf.size(), 8'd0);
			end
		endcase
		put_random(value_len, 1'b0);
		repeat (drop) if (body_buf.size() > 0) body_buf.delete(body_buf.size() - 1);
		add_chunk(ctype);
	endfunction

	function automatic void add_random_chunk();
		int          sel;
		int          kw;
		logic [1:0]  ck;
		logic [31:0] other;
		sel = $urandom_range(0, 99);
		ck = (sel < 30) ? CK_TEXT : (sel < 45) ? CK_ZTXT : CK_ITXT;
		kw = ($urandom_range(0, 19) == 0) ? $urandom_range(78, 84) : $urandom_range(1, 12);
		if (sel < 70) begin
			add_text_chunk(ck, kw, 1'($urandom_range(0, 1)), $urandom_range(0, 16), 0);
		end else if (sel < 85) begin
			other = $urandom;
			put_random($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10), 1'b0);
			add_chunk(other);
		end else begin
			ck = 2'($urandom_range(0, 2));
			case ($urandom_range(0, 2))
				0: add_text_chunk(ck, 0, 1'b0, $urandom_range(0, 6), 0);
				1: add_text_chunk(CK_TEXT, kw, 1'b0, 0, 1);
				default: add_text_chunk(CK_ITXT, kw, 1'($urandom_range(0, 1)), 0,
					$urandom_range(1, 4));
			endcase
		end
	endfunction

	function automatic void build_random_file();
		begin_file();
		repeat ($urandom_range(0, 6)) add_random_chunk();
		if ($urandom_range(0, 9) != 0) add_chunk(TYPE_IEND);
	endfunction

	// Stimulus and pacing.
	task automatic send_byte(input logic [7:0] b, input logic first);
		byte_beat_t beat;
		rec_beat_t  r;
		beat.data_byte = b;
		beat.first_of_file = first;
		byte_beat <= beat;
		byte_valid <= 1'b1;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		sent_bytes++;
		if (parse_byte(beat, r)) expected_recs.insert(expected_recs.size(), r);
	endtask

	task automatic pace_step();
		int gap;
		if (!pace_on) return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		gap = $urandom_range(1, 6);
		byte_valid <= 1'b0;
		repeat (gap) @(posedge clk);
		burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
			: $urandom_range(1, 12);
	endtask

	task automatic wait_idle();
		byte_valid <= 1'b0;
		while (expected_recs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] total, input logic [15:0] limit);
		wr_en <= 1'b1;
		wr_index <= CFG_TOTAL_LENGTH;
		wr_data <= total;
		@(posedge clk);
		m_total = total;
		wr_index <= CFG_ITEM_LIMIT;
		wr_data <= {16'd0, limit};
		@(posedge clk);
		m_limit = limit;
		wr_en <= 1'b0;
	endtask

	task automatic stream_file(input logic [31:0] total, input logic [15:0] limit,
			input int drain_at, input bit restarts);
		wait_idle();
		configure(total, limit);
		for (int i = 0; i < file_buf.size(); i++) begin
			if (i == drain_at) begin
				byte_valid <= 1'b0;
				do @(posedge clk); while (expected_recs.size() != 0);
			end
			send_byte(file_buf[i], i == 0 || (restarts && $urandom_range(0, 49) == 0));
			pace_step();
		end
	endtask

	// Tests.
	task automatic test_reset_defaults();
		send_byte(PNG_SIG[0], 1'b0);
		send_byte(PNG_SIG[1], 1'b0);
	endtask

	task automatic test_signature();
		begin_file();
		add_chunk(TYPE_IEND);
		stream_file(32'd19, ITEM_LIMIT_RST, -1, 1'b0);
		stream_file(MIN_FILE_LEN, ITEM_LIMIT_RST, -1, 1'b0);
		file_buf[5] = 8'h00;
		stream_file(MIN_FILE_LEN, ITEM_LIMIT_RST, -1, 1'b0);
	endtask

	task automatic test_text_items();
		begin_file();
		add_text_chunk(CK_TEXT, 3, 1'b0, 4, 0);
		add_text_chunk(CK_ZTXT, 2, 1'b0, 3, 0);
		add_text_chunk(CK_ITXT, 2, 1'b0, 3, 0);
		add_text_chunk(CK_ITXT, 2, 1'b1, 3, 0);
		add_text_chunk(CK_TEXT, MAX_KEYWORD_DEF, 1'b0, 1, 0);
		add_text_chunk(CK_TEXT, MAX_KEYWORD_DEF + 1, 1'b0, 1, 0);
		add_text_chunk(CK_TEXT, 0, 1'b0, 2, 0);
		add_chunk(TYPE_TEXT);
		put_random(3, 1'b0);
		add_chunk(32'h4944_4154);
		add_text_chunk(CK_TEXT, 4, 1'b0, 0, 1);
		add_text_chunk(CK_ITXT, 3, 1'b0, 0, 1);
		add_chunk(TYPE_IEND);
		stream_file(32'(file_buf.size()), 16'hFFFF, -1, 1'b0);
	endtask

	task automatic test_finish_reasons();
		begin_file();
		add_text_chunk(CK_TEXT, 2, 1'b0, 2, 0);
		stream_file(32'(file_buf.size()), ITEM_LIMIT_RST, -1, 1'b0);
		begin_file();
		push_word(32'h0000_1000);
		push_word(TYPE_TEXT);
		file_buf.insert(file_buf.size(), 8'h41);
		stream_file(32'(file_buf.size()), ITEM_LIMIT_RST, -1, 1'b0);
		begin_file();
		add_text_chunk(CK_TEXT, 2, 1'b0, 1, 0);
		add_text_chunk(CK_TEXT, 2, 1'b0, 1, 0);
		add_chunk(TYPE_IEND);
		stream_file(32'(file_buf.size()), 16'd1, -1, 1'b0);
		stream_file(32'hFFFF_FFFF, 16'd0, -1, 1'b0);
		stream_file(32'hFFFF_FFFF, 16'hFFFF, -1, 1'b0);
	endtask

	task automatic test_random_files();
		logic [31:0] total;
		logic [15:0] limit;
		int          len;
		while (sent_bytes < TOTAL_BYTES) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: limit = 16'hFFFF;
				6, 7: limit = ITEM_LIMIT_RST;
				default: limit = 16'($urandom_range(0, 3));
			endcase
			if ($urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 1) == 0) begin_file();
				else file_buf.delete();
				repeat ($urandom_range(4, 40))
					file_buf.insert(file_buf.size(), 8'($urandom_range(0, 255)));
				total = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 60) : 32'hFFFF_FFFF;
				stream_file(total, limit, -1, 1'b1);
			end else begin
				build_random_file();
				len = file_buf.size();
				case ($urandom_range(0, 9))
					7: total = 32'hFFFF_FFFF;
					8: total = len - $urandom_range(1, (len < 30) ? len : 30);
					9: total = len + $urandom_range(1, 40);
					default: total = len;
				endcase
				stream_file(total, limit, -1, 1'b0);
			end
		end
	endtask

	task automatic test_backpressure();
		pace_on = 1'b0;
		begin_file();
		add_text_chunk(CK_TEXT, 10, 1'b0, 120, 0);
		add_text_chunk(CK_ITXT, 5, 1'b0, 40, 0);
		add_chunk(TYPE_IEND);
		wait_idle();
		hold_req = 400;
		stream_file(32'(file_buf.size()), 16'hFFFF, file_buf.size() / 2, 1'b0);
		pace_on = 1'b1;
	endtask

	// Output stall pattern, with long hold-offs on request.
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			rec_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 10;
					2: stall_pct = 40;
					default: stall_pct = 75;
				endcase
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			rec_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		rec_beat_t want;
		if (arst_n && rec_valid && !rec_stall) begin
			if (expected_recs.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, got %h", $time, rec_beat);
			end else begin
				want = expected_recs.pop_front();
				check_field("kind", 32'(want.kind), 32'(rec_beat.kind));
				check_field("text_byte", 32'(want.text_byte), 32'(rec_beat.text_byte));
				check_field("chunk_kind", 32'(want.chunk_kind), 32'(rec_beat.chunk_kind));
				check_field("item_status", 32'(want.item_status),
					32'(rec_beat.item_status));
				check_field("finish_reason", 32'(want.finish_reason),
					32'(rec_beat.finish_reason));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d beats outstanding", $time, expected_recs.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_signature();
		test_text_items();
		test_finish_reasons();
		test_backpressure();
		test_random_files();
		wait_idle();
		repeat (8) @(posedge clk);
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule
